// File: rtl/cia_pkg.sv
`default_nettype none
package cia_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_INPUT_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH   = 3'd1;
  localparam logic [2:0] REG_OUTPUT_HEIGHT = 3'd2;
  localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd3;
  localparam logic [2:0] REG_PAD_TOP       = 3'd4;
  localparam logic [2:0] REG_PAD_LEFT      = 3'd5;
  localparam logic [2:0] REG_TILED_COUNT   = 3'd6;
  localparam logic [2:0] REG_PIXEL_STRIDE  = 3'd7;

  // Field widths.
  localparam int unsigned POS_W = 24;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned IDX_W = 40;
  localparam int unsigned OFF_W = 44;

  // One word in flight through the divider stages.
  typedef struct packed {
    logic [7:0]       image;
    logic [3:0]       krow;
    logic [3:0]       kcol;
    logic [POS_W-1:0] n_oi;
    logic [POS_W-1:0] pos;
    logic [DIM_W-1:0] r_oi;
    logic [POS_W-1:0] q_oi;
    logic [POS_W-1:0] q_pos;
  } div_word_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] r,
                                              input logic b,
                                              input logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    logic [DIM_W:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, s[DIM_W-1:0]};
    end else begin
      div_step = {1'b0, t[DIM_W-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/conv_indirection_address_gen.sv
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// The depth is set by the bit-serial divider for the output width: one quotient bit
// per stage, 24 stages; the tile split is a reciprocal multiply in the capture stage.
// Reset clears all valid bits and loads the configuration registers with their
// reset values (sizes and counts one, padding zero).
`default_nettype none
module conv_indirection_address_gen #(
  parameter int unsigned KERN_ROWS = 3,
  parameter int unsigned KERN_COLS = 3,
  parameter int unsigned TILE_SIZE = 8,
  parameter int unsigned ROW_STEP  = 1,
  parameter int unsigned COL_STEP  = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [24:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  image_i,
  input  wire logic [23:0] tile_position_i,
  input  wire logic [3:0]  kernel_row_i,
  input  wire logic [3:0]  kernel_col_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [39:0]      entry_index_o,
  output logic [43:0]      pixel_offset_o,
  output logic             is_padding_o
);

  localparam int unsigned DIV_N = cia_pkg::POS_W;
  localparam int unsigned NS    = DIV_N + 5;
  localparam logic [39:0] KSIZE40 = 40'(KERN_ROWS * KERN_COLS);
  localparam logic [39:0] TKM40   = 40'(TILE_SIZE * (KERN_ROWS * KERN_COLS - 1));
  localparam logic [30:0] TILE_RECIP =
    31'(((64'd1 << 30) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE));

  // Configuration registers.
  logic [12:0] ih_q, iw_q, oh_q, ow_q, stride_q;
  logic [3:0]  pt_q, pl_q;
  logic [24:0] tiled_q;
  logic [25:0] last_q;
  logic [12:0] oh_eff, ow_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih_q     <= 13'd1;
      iw_q     <= 13'd1;
      oh_q     <= 13'd1;
      ow_q     <= 13'd1;
      pt_q     <= 4'd0;
      pl_q     <= 4'd0;
      tiled_q  <= 25'd1;
      stride_q <= 13'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cia_pkg::REG_INPUT_HEIGHT:  ih_q     <= cfg_data_i[12:0];
        cia_pkg::REG_INPUT_WIDTH:   iw_q     <= cfg_data_i[12:0];
        cia_pkg::REG_OUTPUT_HEIGHT: oh_q     <= cfg_data_i[12:0];
        cia_pkg::REG_OUTPUT_WIDTH:  ow_q     <= cfg_data_i[12:0];
        cia_pkg::REG_PAD_TOP:       pt_q     <= cfg_data_i[3:0];
        cia_pkg::REG_PAD_LEFT:      pl_q     <= cfg_data_i[3:0];
        cia_pkg::REG_TILED_COUNT:   tiled_q  <= cfg_data_i;
        cia_pkg::REG_PIXEL_STRIDE:  stride_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // A zero output size counts as one.
  assign oh_eff = (oh_q == 13'd0) ? 13'd1 : oh_q;
  assign ow_eff = (ow_q == 13'd0) ? 13'd1 : ow_q;

  // Last real output pixel, updated together with the output size registers.
  logic [12:0] oh_wr, ow_wr, oh_next, ow_next;
  logic [25:0] last_d;

  assign oh_wr   = (cfg_data_i[12:0] == 13'd0) ? 13'd1 : cfg_data_i[12:0];
  assign ow_wr   = oh_wr;
  assign oh_next = (cfg_we_i && cfg_index_i == cia_pkg::REG_OUTPUT_HEIGHT) ? oh_wr : oh_eff;
  assign ow_next = (cfg_we_i && cfg_index_i == cia_pkg::REG_OUTPUT_WIDTH) ? ow_wr : ow_eff;
  assign last_d  = 26'(oh_next) * 26'(ow_next) - 26'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 26'd0;
    end else begin
      last_q <= last_d;
    end
  end

  // Whole pipeline advances together unless the output word is stalled.
  logic          adv;
  logic [NS-1:0] v_q;

  assign adv        = !v_q[NS-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Capture stage: clamp the position, split it into tiles and start the division.
  cia_pkg::div_word_t div_q [DIV_N+1];
  logic [23:0]        oi_clamped;
  logic [54:0]        tile_prod;

  assign oi_clamped = ({2'b00, tile_position_i} < last_q) ? tile_position_i : last_q[23:0];
  assign tile_prod  = 55'(tile_position_i) * 55'(TILE_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].image <= image_i;
      div_q[0].krow  <= kernel_row_i;
      div_q[0].kcol  <= kernel_col_i;
      div_q[0].n_oi  <= oi_clamped;
      div_q[0].pos   <= tile_position_i;
      div_q[0].r_oi  <= '0;
      div_q[0].q_oi  <= '0;
      div_q[0].q_pos <= tile_prod[53:30];
    end
  end

  // Divider stages: one quotient bit of oi / width per stage.
  for (genvar s = 1; s <= DIV_N; s++) begin : g_div
    logic [13:0] st_oi;
    assign st_oi = cia_pkg::div_step(div_q[s-1].r_oi, div_q[s-1].n_oi[23], ow_eff);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[s].image <= div_q[s-1].image;
        div_q[s].krow  <= div_q[s-1].krow;
        div_q[s].kcol  <= div_q[s-1].kcol;
        div_q[s].n_oi  <= {div_q[s-1].n_oi[22:0], 1'b0};
        div_q[s].pos   <= div_q[s-1].pos;
        div_q[s].r_oi  <= st_oi[12:0];
        div_q[s].q_oi  <= {div_q[s-1].q_oi[22:0], st_oi[13]};
        div_q[s].q_pos <= div_q[s-1].q_pos;
      end
    end
  end

  // Post stage 1: input coordinate, bounds check and index partial products.
  // The tile start times the kernel size plus the tile offset equals the position
  // plus the tile number times the tile size times one less than the kernel size.
  cia_pkg::div_word_t dv;
  logic signed [29:0] iy, ix;
  logic               in_image_d;

  assign dv = div_q[DIV_N];
  assign iy = $signed(30'(dv.q_oi) * 30'(ROW_STEP) + 30'(dv.krow) - 30'(pt_q));
  assign ix = $signed(30'(dv.r_oi) * 30'(COL_STEP) + 30'(dv.kcol) - 30'(pl_q));
  assign in_image_d = !iy[29] && (iy < $signed({17'd0, ih_q})) &&
                      !ix[29] && (ix < $signed({17'd0, iw_q}));

  logic        p1_inside_q;
  logic [12:0] p1_iy_q, p1_ix_q;
  logic [32:0] p1_a_q;
  logic [39:0] p1_b_q, p1_c_q;
  logic [20:0] p1_imgih_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_inside_q <= in_image_d;
      p1_iy_q     <= iy[12:0];
      p1_ix_q     <= ix[12:0];
      p1_a_q      <= 33'(dv.image) * 33'(tiled_q);
      p1_b_q      <= 40'(dv.q_pos) * TKM40;
      p1_c_q      <= (40'(dv.krow) * 40'(KERN_COLS) + 40'(dv.kcol)) * 40'(TILE_SIZE)
                     + 40'(dv.pos);
      p1_imgih_q  <= 21'(dv.image) * 21'(ih_q);
    end
  end

  // Post stage 2: input row number and batch term of the slot.
  logic        p2_inside_q;
  logic [12:0] p2_ix_q;
  logic [21:0] p2_row_q;
  logic [39:0] p2_ak_q, p2_bc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_inside_q <= p1_inside_q;
      p2_ix_q     <= p1_ix_q;
      p2_row_q    <= 22'(p1_imgih_q) + 22'(p1_iy_q);
      p2_ak_q     <= 40'(p1_a_q) * KSIZE40;
      p2_bc_q     <= p1_b_q + p1_c_q;
    end
  end

  // Post stage 3: pixel number and final slot.
  logic        p3_inside_q;
  logic [34:0] p3_pix_q;
  logic [39:0] p3_idx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_inside_q <= p2_inside_q;
      p3_pix_q    <= 35'(p2_row_q) * 35'(iw_q) + 35'(p2_ix_q);
      p3_idx_q    <= p2_ak_q + p2_bc_q;
    end
  end

  // Output stage: byte offset, zero for padding entries.
  logic [47:0] off_full;
  logic [43:0] off_q;
  logic [39:0] idx_q;
  logic        pad_q;

  assign off_full = 48'(p3_pix_q) * 48'(stride_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      off_q <= p3_inside_q ? off_full[43:0] : '0;
      idx_q <= p3_idx_q;
      pad_q <= !p3_inside_q;
    end
  end

  assign out_valid_o    = v_q[NS-1];
  assign entry_index_o  = idx_q;
  assign pixel_offset_o = off_q;
  assign is_padding_o   = pad_q;

endmodule
`default_nettype wire
